[sv/gbn_pkg.sv]
// Package for the generic base-n encoder: types, register and opcode codes,
// field widths and the block-size tables. Depends on nothing.
package gbn_pkg;

  localparam int BYTE_BITS = 8;
  localparam int ACC_BITS  = 40;
  localparam int K_BITS    = 3;
  localparam int IDX_BITS  = 6;
  localparam int CHAR_BITS = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SYMBOL_BITS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_CHAR    = 1'd1;

  // Input item opcodes
  localparam logic OP_DATA     = 1'b0;
  localparam logic OP_ALPHABET = 1'b1;

  localparam logic [K_BITS-1:0]    SYMBOL_BITS_RESET = 3'd6;
  localparam logic [CHAR_BITS-1:0] PAD_CHAR_RESET    = 8'd61;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } gbn_state_t;

  // Bytes per block for symbol width k (k already clamped to 1..6)
  function automatic logic [2:0] blk_bytes(input logic [K_BITS-1:0] k);
    logic [2:0] r;
    case (k)
      3'd3:    r = 3'd3;
      3'd5:    r = 3'd5;
      3'd6:    r = 3'd3;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

  // Symbols per block for symbol width k
  function automatic logic [3:0] blk_syms(input logic [K_BITS-1:0] k);
    logic [3:0] r;
    case (k)
      3'd2:    r = 4'd4;
      3'd4:    r = 4'd2;
      3'd6:    r = 4'd4;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  // Clamp a written symbol width into 1..6
  function automatic logic [K_BITS-1:0] eff_bits(input logic [K_BITS-1:0] v);
    logic [K_BITS-1:0] r;
    case (v)
      3'd0:    r = 3'd1;
      3'd7:    r = 3'd6;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[sv/gbn_in_if.sv]
// Input channel of the generic base-n encoder: valid/ready and one item.
// Depends on gbn_pkg for the field widths.
interface gbn_in_if
  import gbn_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [7:0]           data_byte;
  logic                 is_final;
  logic [IDX_BITS-1:0]  alphabet_index;
  logic [CHAR_BITS-1:0] alphabet_char;

  modport source (output valid, opcode, data_byte, is_final, alphabet_index,
                  alphabet_char, input ready);
  modport sink   (input valid, opcode, data_byte, is_final, alphabet_index,
                  alphabet_char, output ready);
endinterface

// Output channel of the generic base-n encoder: valid/ready and one symbol.
interface gbn_out_if
  import gbn_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] symbol_char;
  logic                 run_end;

  modport source (output valid, symbol_char, run_end, input ready);
  modport sink   (input valid, symbol_char, run_end, output ready);
endinterface

[sv/generic_base_n_encoder.sv]
// Top level of the generic base-n encoder: block gathering, alphabet memory
// and symbol output pipeline. Depends on gbn_pkg and the channel interfaces.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+------------------------------------------
//   din     | in  | valid/ready     | opcode, data_byte, is_final, alphabet_*
//   dout    | out | valid/ready     | symbol_char, run_end
//   cfg     | in  | cfg_we only     | cfg_index, cfg_data
//
// A data byte or alphabet write that gives no symbols is taken while idle. A byte
// that closes a block is followed by spb symbol reads (spb = 2, 4 or 8): the alphabet
// memory has a single read port and yields one symbol per cycle unless the output stalls.
// Symbols leave through a read stage and an output register, so a new item is
// taken while the last symbols of a block still drain.
// Synchronous active-high reset; the alphabet memory is not cleared.
// A stalled output holds the pipeline; reads are issued only into free slots.
module generic_base_n_encoder
  import gbn_pkg::*;
#(
  parameter int ALPHABET_DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  gbn_in_if.sink                   din,
  gbn_out_if.source                dout,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = (ALPHABET_DEPTH > 1) ? $clog2(ALPHABET_DEPTH) : 1;
  localparam logic [IDX_BITS:0] DEPTH_W = (IDX_BITS+1)'(ALPHABET_DEPTH);

  // Configuration and block state
  logic [K_BITS-1:0]    k_eff;
  logic [CHAR_BITS-1:0] pad;
  logic [ACC_BITS-1:0]  acc;
  logic [2:0]           cnt;

  // Emission state
  gbn_state_t           state, state_next;
  logic [ACC_BITS-1:0]  emit_bits;
  logic [5:0]           bit_pos;
  logic [5:0]           data_bits;
  logic [2:0]           sym_left;

  // Read stage and output register
  logic                 s1_valid, s1_pad, s1_oob, s1_last;
  logic [CHAR_BITS-1:0] rd_data;
  logic                 s2_valid, s2_last;
  logic [CHAR_BITS-1:0] s2_char;

  logic [CHAR_BITS-1:0] mem [ALPHABET_DEPTH];

  logic                 accept, data_acc, alpha_acc, fire, issue, s1_adv;
  logic [ACC_BITS-1:0]  acc_new, emit_load;
  logic [2:0]           cnt_new;
  logic [5:0]           grp;

  // Gather the incoming byte
  assign accept    = din.valid && din.ready;
  assign data_acc  = accept && (din.opcode == OP_DATA);
  assign alpha_acc = accept && (din.opcode == OP_ALPHABET);
  assign acc_new   = {acc[ACC_BITS-BYTE_BITS-1:0], din.data_byte};
  assign cnt_new   = cnt + 3'd1;
  assign fire      = data_acc && ((cnt_new >= blk_bytes(k_eff)) || din.is_final);

  // Left-align the block so the first group sits at the top, zero-filled
  always_comb begin
    case (cnt_new)
      3'd1:    emit_load = acc_new << 32;
      3'd2:    emit_load = acc_new << 24;
      3'd3:    emit_load = acc_new << 16;
      3'd4:    emit_load = acc_new << 8;
      default: emit_load = acc_new;
    endcase
  end

  // Current group: top k bits of the aligned block
  assign grp    = emit_bits[ACC_BITS-1 -: 6] >> (3'd6 - k_eff);
  assign s1_adv = s1_valid && (!s2_valid || dout.ready);

  // Sequencer: next state, input ready and read issue; hold off input in reset
  always_comb begin
    state_next = state;
    din.ready  = 1'b0;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        din.ready = !rst;
        if (fire) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        issue = !s1_valid || s1_adv;
        if (issue && (sym_left == 3'd0)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration registers and block accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff <= SYMBOL_BITS_RESET;
      pad   <= PAD_CHAR_RESET;
      acc   <= '0;
      cnt   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SYMBOL_BITS) begin
        k_eff <= eff_bits(cfg_data[K_BITS-1:0]);
        acc   <= '0;
        cnt   <= '0;
      end else if (cfg_index == REG_PAD_CHAR) begin
        pad <= cfg_data;
      end
    end else if (fire) begin
      acc <= '0;
      cnt <= '0;
    end else if (data_acc) begin
      acc <= acc_new;
      cnt <= cnt_new;
    end
  end

  // Load the block on fire, advance one group per issued read
  always_ff @(posedge clk) begin
    if (fire) begin
      emit_bits <= emit_load;
      bit_pos   <= '0;
      data_bits <= {cnt_new, 3'b000};
      sym_left  <= 3'(blk_syms(k_eff) - 4'd1);
    end else if (issue) begin
      emit_bits <= emit_bits << k_eff;
      bit_pos   <= bit_pos + {3'b000, k_eff};
      sym_left  <= sym_left - 3'd1;
    end
  end

  // Alphabet memory: write on alphabet items, read one group per issue
  always_ff @(posedge clk) begin
    if (alpha_acc && ({1'b0, din.alphabet_index} < DEPTH_W))
      mem[din.alphabet_index[AW-1:0]] <= din.alphabet_char;
    if (issue)
      rd_data <= mem[grp[AW-1:0]];
  end

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pad  <= !(bit_pos < data_bits);
      s1_oob  <= !({1'b0, grp} < DEPTH_W);
      s1_last <= (sym_left == 3'd0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (dout.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last <= s1_last;
      if (s1_pad)      s2_char <= pad;
      else if (s1_oob) s2_char <= '0;
      else             s2_char <= rd_data;
    end
  end

  assign dout.valid       = s2_valid;
  assign dout.symbol_char = s2_char;
  assign dout.run_end     = s2_last;

  // The last read of a block returns the sequencer to idle
  a_last_issue_idle: assert property (@(posedge clk) disable iff (rst)
    (issue && (sym_left == 3'd0)) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after the last group");

  // A partial block never holds a full block's worth of bytes
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt < blk_bytes(k_eff))
    else $error("block byte count reached block size");

  // A symbol width write discards the partial block
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == REG_SYMBOL_BITS)) |=> ((cnt == 3'd0) && (acc == '0)))
    else $error("symbol width write left block state behind");

  // Symbol width always stays within one to six
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (k_eff != 3'd0) && (k_eff != 3'd7))
    else $error("symbol width out of range");

endmodule
